>>> rtl/gbe_pkg.sv
package gbe_pkg;

    // Fixed field widths.
    localparam int VW = 7;
    localparam int FW = 4;
    localparam int RW = 16;
    localparam int DW = 6;

    // Request codes.
    localparam logic [FW-1:0] FN_ADD_EDGE  = 4'd0;
    localparam logic [FW-1:0] FN_ADD_ARC   = 4'd1;
    localparam logic [FW-1:0] FN_CLEAR     = 4'd2;
    localparam logic [FW-1:0] FN_RUN_BFS   = 4'd3;
    localparam logic [FW-1:0] FN_PARENT    = 4'd4;
    localparam logic [FW-1:0] FN_DISTANCE  = 4'd5;
    localparam logic [FW-1:0] FN_PATH      = 4'd6;
    localparam logic [FW-1:0] FN_ORDER     = 4'd7;
    localparam logic [FW-1:0] FN_EDGES     = 4'd8;
    localparam logic [FW-1:0] FN_SOURCE    = 4'd9;

    // Longest parent walk before the source is pushed.
    localparam logic [VW-1:0] PATH_LIMIT = 7'd63;
    localparam logic [RW-1:0] EDGE_MAX   = 16'hFFFF;

    // Register index of vertex_count.
    localparam logic REG_VCOUNT = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_WR_A,
        S_EDGE_RD_B,
        S_EDGE_WR_B,
        S_BFS_DEQ,
        S_BFS_DEQ_W,
        S_BFS_ROW,
        S_BFS_SCAN,
        S_Q_EM,
        S_WALK_CHK,
        S_WALK_W,
        S_POP_RD,
        S_POP_EM
    } t_state;

    // Control of the adjacency row memory.
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_adj_ctl;

endpackage

>>> rtl/graph_bfs_engine.sv
// Breadth-first search engine over a graph of up to MAX_VERTICES vertices held as an
// adjacency bit matrix. A request is taken when start is high and busy is low; results
// come out one per strobe and cannot be stalled, so the receiver must take every strobe.
// A search reads each dequeued vertex's row from the single-port row memory, then the
// lowest-bit finder picks one newly found neighbor a cycle, lowest first. A path query
// walks the parent table back to the source, pushing each vertex on a stack, and then
// pops the stack to emit the path from the source, one vertex per strobe.
module graph_bfs_engine
    import gbe_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [FW-1:0] i_func,
    input  logic [VW-1:0] i_vertex_a,
    input  logic [VW-1:0] i_vertex_b,
    output logic          o_result_strobe,
    output logic [RW-1:0] o_result_value,
    output logic          o_is_nil,
    output logic          o_last,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = IW + 1;
    localparam int MV = MAX_VERTICES;

    t_state r_state, n_state;

    logic [VW-1:0] r_vcount;
    logic [VW-1:0] r_src, n_src;
    logic          r_done, n_done;
    logic [RW-1:0] r_edges, n_edges;
    logic [MV-1:0] r_reached, n_reached;
    logic [FW-1:0] r_func, n_func;
    logic [VW-1:0] r_a, n_a;
    logic [IW-1:0] r_bi, n_bi;
    logic          r_both, n_both;
    logic [CW-1:0] r_head, n_head;
    logic [CW-1:0] r_tail, n_tail;
    logic [IW-1:0] r_x, n_x;
    logic [DW-1:0] r_dx, n_dx;
    logic [MV-1:0] r_fresh, n_fresh;
    logic [VW-1:0] r_v, n_v;
    logic [VW-1:0] r_depth, n_depth;
    logic          r_strobe, n_strobe;
    logic [RW-1:0] r_value, n_value;
    logic          r_nil, n_nil;
    logic          r_last, n_last;

    // Tables, queue and path stack.
    logic [DW-1:0] dist_mem  [MV];
    logic [VW-1:0] par_mem   [MV];
    logic [IW-1:0] queue_mem [MV];
    logic [VW-1:0] stk_mem   [MV];
    logic [DW-1:0] r_dist_q;
    logic [VW-1:0] r_par_q;
    logic [IW-1:0] r_queue_q;
    logic [VW-1:0] r_stk_q;

    logic          dist_we, dist_re, par_we, par_re, q_we, q_re, stk_we, stk_re;
    logic [IW-1:0] dist_waddr, dist_raddr, par_waddr, par_raddr;
    logic [IW-1:0] q_waddr, q_raddr, stk_waddr, stk_raddr;
    logic [DW-1:0] dist_wdata;
    logic [VW-1:0] par_wdata, stk_wdata;
    logic [IW-1:0] q_wdata;

    t_adj_ctl      adj_ctl;
    logic [IW-1:0] adj_addr;
    logic [MV-1:0] adj_wdata;
    logic [MV-1:0] adj_rdata;

    logic [IW-1:0] ffs_idx;
    logic          ffs_any;

    logic          accept;
    logic [VW-1:0] n_used;
    logic [MV-1:0] vmask;
    logic          a_ok, b_ok;
    logic [IW-1:0] ai, bi, vi;
    logic          q_ok, q_reached;

    // Vertices in use and validity checks.
    assign n_used = (r_vcount > VW'(MV)) ? VW'(MV) : r_vcount;
    always_comb begin
        for (int i = 0; i < MV; i++) begin
            vmask[i] = (VW'(i) < n_used);
        end
    end
    assign a_ok      = (i_vertex_a != '0) && (i_vertex_a <= n_used);
    assign b_ok      = (i_vertex_b != '0) && (i_vertex_b <= n_used);
    assign ai        = IW'(i_vertex_a - VW'(1));
    assign bi        = IW'(i_vertex_b - VW'(1));
    assign vi        = IW'(r_v - VW'(1));
    assign q_ok      = r_done && a_ok;
    assign q_reached = q_ok && r_reached[ai];
    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = {{(32 - VW){1'b0}}, r_vcount};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= 7'd64;
        end else if (psel && penable && pwrite && (paddr[2] == REG_VCOUNT)) begin
            r_vcount <= pwdata[VW-1:0];
        end
    end

    gbe_adj_ram #(.W(MV), .IW(IW)) u_adj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (adj_ctl),
        .i_addr  (adj_addr),
        .i_wdata (adj_wdata),
        .o_rdata (adj_rdata)
    );

    gbe_ffs #(.W(MV), .IW(IW)) u_ffs (
        .i_mask (r_fresh),
        .o_idx  (ffs_idx),
        .o_any  (ffs_any)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_func == FN_ADD_EDGE || i_func == FN_ADD_ARC) && a_ok && b_ok) begin
                        n_state = S_EDGE_WR_A;
                    end else if (i_func == FN_RUN_BFS && a_ok) begin
                        n_state = S_BFS_DEQ;
                    end else if ((i_func == FN_PARENT || i_func == FN_DISTANCE) && q_reached) begin
                        n_state = S_Q_EM;
                    end else if (i_func == FN_PATH && q_reached) begin
                        n_state = S_WALK_CHK;
                    end
                end
            end
            S_EDGE_WR_A: begin
                n_state = r_both ? S_EDGE_RD_B : S_IDLE;
            end
            S_EDGE_RD_B: begin
                n_state = S_EDGE_WR_B;
            end
            S_EDGE_WR_B: begin
                n_state = S_IDLE;
            end
            S_BFS_DEQ: begin
                n_state = (r_head < r_tail) ? S_BFS_DEQ_W : S_IDLE;
            end
            S_BFS_DEQ_W: begin
                n_state = S_BFS_ROW;
            end
            S_BFS_ROW: begin
                n_state = S_BFS_SCAN;
            end
            S_BFS_SCAN: begin
                if (!ffs_any) begin
                    n_state = S_BFS_DEQ;
                end
            end
            S_Q_EM: begin
                n_state = S_IDLE;
            end
            S_WALK_CHK: begin
                if (r_v != r_src && r_depth < PATH_LIMIT && r_v != '0) begin
                    n_state = S_WALK_W;
                end else begin
                    n_state = S_POP_RD;
                end
            end
            S_WALK_W: begin
                n_state = S_WALK_CHK;
            end
            S_POP_RD: begin
                n_state = S_POP_EM;
            end
            S_POP_EM: begin
                n_state = (r_depth == VW'(1)) ? S_IDLE : S_POP_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_src = r_src;   n_done = r_done;   n_edges = r_edges;   n_reached = r_reached;
        n_func = r_func; n_a = r_a;         n_bi = r_bi;         n_both = r_both;
        n_head = r_head; n_tail = r_tail;   n_x = r_x;           n_dx = r_dx;
        n_fresh = r_fresh; n_v = r_v;       n_depth = r_depth;
        n_strobe = 1'b0; n_value = '0;      n_nil = 1'b0;        n_last = 1'b1;
        adj_ctl = '0;    adj_addr = '0;     adj_wdata = '0;
        dist_we = 1'b0;  dist_waddr = '0;   dist_wdata = '0;  dist_re = 1'b0; dist_raddr = '0;
        par_we = 1'b0;   par_waddr = '0;    par_wdata = '0;   par_re = 1'b0;  par_raddr = '0;
        q_we = 1'b0;     q_waddr = '0;      q_wdata = '0;     q_re = 1'b0;    q_raddr = '0;
        stk_we = 1'b0;   stk_waddr = '0;    stk_wdata = '0;   stk_re = 1'b0;  stk_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func = i_func;
                    n_a    = i_vertex_a;
                    case (i_func)
                        FN_ADD_EDGE, FN_ADD_ARC: begin
                            // Read the tail row now, merge the new bit next cycle.
                            adj_ctl.rd = 1'b1;
                            adj_addr   = ai;
                            n_bi       = bi;
                            n_both     = (i_func == FN_ADD_EDGE);
                            if (i_func == FN_ADD_EDGE && a_ok && b_ok && r_edges != EDGE_MAX) begin
                                n_edges = r_edges + RW'(1);
                            end
                        end
                        FN_CLEAR: begin
                            adj_ctl.clr = 1'b1;
                            n_reached   = '0;
                            n_edges     = '0;
                            n_src       = '0;
                            n_done      = 1'b0;
                        end
                        FN_RUN_BFS: begin
                            n_done    = 1'b1;
                            n_src     = i_vertex_a;
                            n_reached = '0;
                            if (a_ok) begin
                                n_reached  = MV'(1) << ai;
                                dist_we    = 1'b1;
                                dist_waddr = ai;
                                par_we     = 1'b1;
                                par_waddr  = ai;
                                q_we       = 1'b1;
                                q_waddr    = '0;
                                q_wdata    = ai;
                                n_head     = '0;
                                n_tail     = CW'(1);
                            end
                        end
                        FN_PARENT, FN_DISTANCE: begin
                            dist_re    = 1'b1;
                            dist_raddr = ai;
                            par_re     = 1'b1;
                            par_raddr  = ai;
                            if (!q_reached) begin
                                n_strobe = 1'b1;
                                n_nil    = 1'b1;
                            end
                        end
                        FN_PATH: begin
                            n_v     = i_vertex_a;
                            n_depth = '0;
                            if (q_ok && !q_reached) begin
                                n_strobe = 1'b1;
                                n_nil    = 1'b1;
                            end
                        end
                        FN_ORDER: begin
                            n_strobe = 1'b1;
                            n_value  = RW'(n_used);
                        end
                        FN_EDGES: begin
                            n_strobe = 1'b1;
                            n_value  = r_edges;
                        end
                        FN_SOURCE: begin
                            n_strobe = 1'b1;
                            n_value  = r_done ? RW'(r_src) : '0;
                            n_nil    = !r_done;
                        end
                        default: begin
                            n_strobe = 1'b0;
                        end
                    endcase
                end
            end
            S_EDGE_WR_A: begin
                // Write the tail row.
                adj_ctl.wr = 1'b1;
                adj_addr   = IW'(r_a - VW'(1));
                adj_wdata  = adj_rdata | (MV'(1) << r_bi);
            end
            S_EDGE_RD_B: begin
                // Fetch the head row once the tail row is stored.
                adj_ctl.rd = 1'b1;
                adj_addr   = r_bi;
            end
            S_EDGE_WR_B: begin
                adj_ctl.wr = 1'b1;
                adj_addr   = r_bi;
                adj_wdata  = adj_rdata | (MV'(1) << IW'(r_a - VW'(1)));
            end
            S_BFS_DEQ: begin
                q_re    = 1'b1;
                q_raddr = r_head[IW-1:0];
                if (r_head < r_tail) begin
                    n_head = r_head + CW'(1);
                end
            end
            S_BFS_DEQ_W: begin
                n_x        = r_queue_q;
                adj_ctl.rd = 1'b1;
                adj_addr   = r_queue_q;
                dist_re    = 1'b1;
                dist_raddr = r_queue_q;
            end
            S_BFS_ROW: begin
                n_fresh = adj_rdata & vmask & ~r_reached;
                n_dx    = r_dist_q;
            end
            S_BFS_SCAN: begin
                // One newly found neighbor per cycle, lowest first.
                if (ffs_any) begin
                    n_reached[ffs_idx] = 1'b1;
                    n_fresh[ffs_idx]   = 1'b0;
                    dist_we    = 1'b1;
                    dist_waddr = ffs_idx;
                    dist_wdata = r_dx + DW'(1);
                    par_we     = 1'b1;
                    par_waddr  = ffs_idx;
                    par_wdata  = VW'(r_x) + VW'(1);
                    if (r_tail < CW'(MV)) begin
                        q_we    = 1'b1;
                        q_waddr = r_tail[IW-1:0];
                        q_wdata = ffs_idx;
                        n_tail  = r_tail + CW'(1);
                    end
                end
            end
            S_Q_EM: begin
                n_strobe = 1'b1;
                if (r_func == FN_DISTANCE) begin
                    n_value = RW'(r_dist_q);
                end else if (r_a != r_src) begin
                    n_value = RW'(r_par_q);
                end else begin
                    n_nil = 1'b1;
                end
            end
            S_WALK_CHK: begin
                // Push the vertex and fetch its parent, or finish with the source.
                stk_we    = 1'b1;
                stk_waddr = r_depth[IW-1:0];
                n_depth   = r_depth + VW'(1);
                if (r_v != r_src && r_depth < PATH_LIMIT && r_v != '0) begin
                    stk_wdata = r_v;
                    par_re    = 1'b1;
                    par_raddr = vi;
                end else begin
                    stk_wdata = r_src;
                end
            end
            S_WALK_W: begin
                n_v = r_par_q;
            end
            S_POP_RD: begin
                stk_re    = 1'b1;
                stk_raddr = IW'(r_depth - VW'(1));
            end
            S_POP_EM: begin
                n_strobe = 1'b1;
                n_value  = RW'(r_stk_q);
                n_last   = (r_depth == VW'(1));
                n_depth  = r_depth - VW'(1);
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_src     <= '0;
            r_done    <= 1'b0;
            r_edges   <= '0;
            r_reached <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_src     <= n_src;
            r_done    <= n_done;
            r_edges   <= n_edges;
            r_reached <= n_reached;
            r_strobe  <= n_strobe;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_a     <= n_a;
        r_bi    <= n_bi;
        r_both  <= n_both;
        r_head  <= n_head;
        r_tail  <= n_tail;
        r_x     <= n_x;
        r_dx    <= n_dx;
        r_fresh <= n_fresh;
        r_v     <= n_v;
        r_depth <= n_depth;
        r_value <= n_value;
        r_nil   <= n_nil;
        r_last  <= n_last;
    end

    // Distance and parent tables.
    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        if (dist_re) begin
            r_dist_q <= dist_mem[dist_raddr];
        end
        if (par_we) begin
            par_mem[par_waddr] <= par_wdata;
        end
        if (par_re) begin
            r_par_q <= par_mem[par_raddr];
        end
    end

    // Visit queue and path stack.
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            r_queue_q <= queue_mem[q_raddr];
        end
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stk_q <= stk_mem[stk_raddr];
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result_value  = r_value;
    assign o_is_nil        = r_nil;
    assign o_last          = r_last;

endmodule

>>> rtl/gbe_ffs.sv
module gbe_ffs
    import gbe_pkg::*;
#(
    parameter int W  = 64,
    parameter int IW = 6
) (
    input  logic [W-1:0]  i_mask,
    output logic [IW-1:0] o_idx,
    output logic          o_any
);

    // Lowest set bit wins, so neighbors come out in ascending order.
    always_comb begin
        o_idx = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (i_mask[i]) begin
                o_idx = IW'(i);
            end
        end
        o_any = |i_mask;
    end

endmodule

>>> rtl/gbe_adj_ram.sv
module gbe_adj_ram
    import gbe_pkg::*;
#(
    parameter int W  = 64,
    parameter int IW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_adj_ctl      i_ctl,
    input  logic [IW-1:0] i_addr,
    input  logic [W-1:0]  i_wdata,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [W];
    logic [W-1:0] r_valid;
    logic [W-1:0] r_rdata;
    logic         r_rd_valid;

    // Row valid bits; a clear empties the whole graph at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clr) begin
            r_valid <= '0;
        end else if (i_ctl.wr) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    // Row storage with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata    <= r_mem[i_addr];
            r_rd_valid <= r_valid[i_addr];
        end
    end

    // A row never written reads as empty.
    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

>>> verif/gbe_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register channels of the search engine,
// predicts every answer and compares each strobed result with the oldest one.
module gbe_checker
    import gbe_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          busy,
    input  logic [FW-1:0] i_func,
    input  logic [VW-1:0] i_vertex_a,
    input  logic [VW-1:0] i_vertex_b,
    input  logic          o_result_strobe,
    input  logic [RW-1:0] o_result_value,
    input  logic          o_is_nil,
    input  logic          o_last,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    input  logic          pready,
    output int            o_fail_count,
    output int            o_pending
);

    typedef struct packed {
        logic [RW-1:0] value;
        logic          nil;
        logic          last;
    } t_answer;

    t_answer         answer_q[$];
    logic [63:0]     adj_rows[64];
    logic [DW-1:0]   hop_dist[64];
    logic [VW-1:0]   hop_parent[64];
    logic [63:0]     reached;
    logic [VW-1:0]   src_vertex;
    logic            searched;
    logic [RW-1:0]   edge_cnt;
    logic [VW-1:0]   vcount;

    function automatic int used_vertices();
        return (vcount > 64) ? 64 : int'(vcount);
    endfunction

    function automatic bit vertex_ok(logic [VW-1:0] v);
        return (v >= 1) && (int'(v) <= used_vertices());
    endfunction

    // Breadth-first walk, lowest-numbered neighbor first.
    function automatic void walk_graph(logic [VW-1:0] s);
        logic [63:0] vmask;
        logic [63:0] fresh;
        int          order_q[64];
        int          head;
        int          tail;
        int          x;
        logic [5:0]  si;
        vmask = (used_vertices() >= 64) ? '1 : ((64'd1 << used_vertices()) - 64'd1);
        si = s[5:0] - 6'd1;
        reached = 64'd1 << si;
        hop_dist[si] = '0;
        hop_parent[si] = '0;
        order_q[0] = si;
        head = 0;
        tail = 1;
        while (head < tail && head < 64) begin
            x = order_q[head];
            head++;
            fresh = adj_rows[x] & vmask & ~reached;
            for (int y = 0; y < 64; y++) begin
                if (fresh[y]) begin
                    reached[y] = 1'b1;
                    hop_dist[y] = hop_dist[x] + 6'd1;
                    hop_parent[y] = VW'(x + 1);
                    if (tail < 64) begin
                        order_q[tail] = y;
                        tail++;
                    end
                end
            end
        end
    endfunction

    function automatic void push_answer(logic [RW-1:0] v, logic nil, logic lst);
        t_answer r;
        r.value = v;
        r.nil = nil;
        r.last = lst;
        answer_q.push_back(r);
    endfunction

    // Apply one accepted request and queue the answers it causes.
    function automatic void apply_request(logic [FW-1:0] f, logic [VW-1:0] a,
                                          logic [VW-1:0] b);
        logic [5:0]    ai;
        logic [5:0]    bi;
        bit            ok;
        bit            hit;
        logic [VW-1:0] v;
        logic [VW-1:0] trail[$];
        ai = a[5:0] - 6'd1;
        bi = b[5:0] - 6'd1;
        ok = searched && vertex_ok(a);
        hit = ok && reached[ai];
        case (f)
            FN_ADD_EDGE: begin
                if (vertex_ok(a) && vertex_ok(b)) begin
                    adj_rows[ai][bi] = 1'b1;
                    adj_rows[bi][ai] = 1'b1;
                    if (edge_cnt != EDGE_MAX) edge_cnt++;
                end
            end
            FN_ADD_ARC: begin
                if (vertex_ok(a) && vertex_ok(b)) adj_rows[ai][bi] = 1'b1;
            end
            FN_CLEAR: begin
                foreach (adj_rows[i]) adj_rows[i] = '0;
                reached = '0;
                edge_cnt = '0;
                src_vertex = '0;
                searched = 1'b0;
            end
            FN_RUN_BFS: begin
                searched = 1'b1;
                src_vertex = a;
                reached = '0;
                if (vertex_ok(a)) walk_graph(a);
            end
            FN_PARENT: begin
                if (hit && a != src_vertex) push_answer(RW'(hop_parent[ai]), 1'b0, 1'b1);
                else push_answer('0, 1'b1, 1'b1);
            end
            FN_DISTANCE: begin
                if (hit) push_answer(RW'(hop_dist[ai]), 1'b0, 1'b1);
                else push_answer('0, 1'b1, 1'b1);
            end
            FN_PATH: begin
                if (ok && !hit) begin
                    push_answer('0, 1'b1, 1'b1);
                end else if (ok) begin
                    // Walk parents back to the source, then emit source first.
                    v = a;
                    while (v != src_vertex && trail.size() < 63 && v >= 1) begin
                        trail.push_back(v);
                        v = hop_parent[v[5:0] - 6'd1];
                    end
                    trail.push_back(src_vertex);
                    for (int k = trail.size() - 1; k >= 0; k--)
                        push_answer(RW'(trail[k]), 1'b0, k == 0);
                end
            end
            FN_ORDER:  push_answer(RW'(used_vertices()), 1'b0, 1'b1);
            FN_EDGES:  push_answer(edge_cnt, 1'b0, 1'b1);
            FN_SOURCE: begin
                if (searched) push_answer(RW'(src_vertex), 1'b0, 1'b1);
                else push_answer('0, 1'b1, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // Compare results, then take requests and register writes.
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            foreach (adj_rows[i]) adj_rows[i] = '0;
            reached = '0;
            src_vertex = '0;
            searched = 1'b0;
            edge_cnt = '0;
            vcount = 7'd64;
            answer_q.delete();
            o_fail_count <= 0;
        end else begin
            if (o_result_strobe) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result value=%0d nil=%0d last=%0d",
                             $time, o_result_value, o_is_nil, o_last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (want.value !== o_result_value || want.nil !== o_is_nil ||
                        want.last !== o_last) begin
                        $display("%0t: mismatch expected value=%0d nil=%0d last=%0d, actual value=%0d nil=%0d last=%0d",
                                 $time, want.value, want.nil, want.last,
                                 o_result_value, o_is_nil, o_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy) apply_request(i_func, i_vertex_a, i_vertex_b);
            if (psel && penable && pwrite && pready && paddr == {2'b00, REG_VCOUNT})
                vcount = pwdata[VW-1:0];
        end
        o_pending <= answer_q.size();
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import gbe_pkg::*;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [FW-1:0] i_func;
    logic [VW-1:0] i_vertex_a;
    logic [VW-1:0] i_vertex_b;
    logic          o_result_strobe;
    logic [RW-1:0] o_result_value;
    logic          o_is_nil;
    logic          o_last;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    int            fail_count;
    int            pending;
    int            sent;
    int            nv;
    bit            gaps_on;

    graph_bfs_engine dut (.*);

    gbe_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_func, .i_vertex_a, .i_vertex_b,
        .o_result_strobe, .o_result_value, .o_is_nil, .o_last,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hold a request until the engine takes it.
    task automatic send(logic [FW-1:0] f, logic [VW-1:0] a, logic [VW-1:0] b);
        start <= 1'b1;
        i_func <= f;
        i_vertex_a <= a;
        i_vertex_b <= b;
        do @(posedge i_clk); while (busy);
        sent++;
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge i_clk);
            else repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Let the engine drain all answers and finish any search before moving on.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_vcount(int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {2'b00, REG_VCOUNT};
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        nv = (value > 64) ? 64 : value;
    endtask

    // Mostly a vertex in use, sometimes any 7-bit value.
    function automatic logic [VW-1:0] pick_vertex();
        if (nv == 0 || $urandom_range(0, 9) == 0) return VW'($urandom_range(0, 127));
        return VW'($urandom_range(1, nv));
    endfunction

    task automatic random_phase();
        int edge_n;
        int query_n;
        int pick;
        if ($urandom_range(0, 3) != 0)
            send(FN_CLEAR, VW'($urandom), VW'($urandom));
        edge_n = (nv < 2) ? 3 : $urandom_range(nv, 2 * nv);
        if (edge_n > 30) edge_n = 30;
        for (int i = 0; i < edge_n; i++)
            send(($urandom_range(0, 3) != 0) ? FN_ADD_EDGE : FN_ADD_ARC,
                 pick_vertex(), pick_vertex());
        send(FN_RUN_BFS, pick_vertex(), VW'($urandom));
        query_n = $urandom_range(8, 20);
        for (int i = 0; i < query_n; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 4)       send(FN_PATH, pick_vertex(), VW'($urandom));
            else if (pick < 8)  send(FN_PARENT, pick_vertex(), VW'($urandom));
            else if (pick < 12) send(FN_DISTANCE, pick_vertex(), VW'($urandom));
            else if (pick == 12) send(FN_ORDER, VW'($urandom), VW'($urandom));
            else if (pick == 13) send(FN_EDGES, VW'($urandom), VW'($urandom));
            else if (pick == 14) send(FN_SOURCE, VW'($urandom), VW'($urandom));
            else if (pick == 15) send(FN_RUN_BFS, pick_vertex(), VW'($urandom));
            else if (pick == 16) send(FN_ADD_EDGE, pick_vertex(), pick_vertex());
            else if (pick == 17) send(FW'($urandom_range(10, 15)), VW'($urandom),
                                      VW'($urandom));
            else send(FW'($urandom), VW'($urandom), VW'($urandom));
        end
    endtask

    initial begin
        int vc_list[12];
        vc_list = '{64, 1, 8, 12, 2, 16, 127, 0, 5, 10, 33, 64};
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_func <= '0;
        i_vertex_a <= '0;
        i_vertex_b <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        sent = 0;
        nv = 64;
        gaps_on = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: queries before any search, extremes, invalid endpoints and sources.
        send(FN_SOURCE, 7'd0, 7'd0);
        send(FN_PARENT, 7'd1, 7'd0);
        send(FN_DISTANCE, 7'd64, 7'd0);
        send(FN_PATH, 7'd1, 7'd0);
        send(FN_ORDER, 7'd127, 7'd127);
        send(FN_ADD_EDGE, 7'd1, 7'd64);
        send(FN_ADD_EDGE, 7'd1, 7'd64);
        send(FN_ADD_ARC, 7'd64, 7'd2);
        send(FN_ADD_EDGE, 7'd0, 7'd5);
        send(FN_ADD_EDGE, 7'd65, 7'd3);
        send(FN_ADD_ARC, 7'd3, 7'd127);
        send(FN_EDGES, 7'd0, 7'd0);
        send(FN_RUN_BFS, 7'd1, 7'd0);
        send(FN_PATH, 7'd2, 7'd0);
        send(FN_PATH, 7'd1, 7'd0);
        send(FN_PATH, 7'd30, 7'd0);
        send(FN_PARENT, 7'd1, 7'd0);
        send(FN_DISTANCE, 7'd2, 7'd0);
        send(FN_PARENT, 7'd64, 7'd0);
        send(FN_RUN_BFS, 7'd100, 7'd0);
        send(FN_SOURCE, 7'd0, 7'd0);
        send(FN_PATH, 7'd1, 7'd0);
        send(4'd15, 7'd1, 7'd2);
        send(FN_CLEAR, 7'd0, 7'd0);
        send(FN_SOURCE, 7'd0, 7'd0);

        // Hold off until every answer so far has come back.
        drain();

        gaps_on = 1'b1;
        for (int p = 0; sent < 380; p++) begin
            write_vcount(vc_list[p % 12]);
            gaps_on = (p % 4 != 3);
            random_phase();
            drain();
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
